### rtl/kpt_pkg.sv
`timescale 1ns / 1ps
package kpt_pkg;

  localparam int FracBits    = 16;
  localparam int PointW      = FracBits + 1;
  localparam int SlopeW      = FracBits + 5;
  localparam int DegW        = 4;
  localparam int MaxDegree   = 15;
  localparam int NumPowCells = MaxDegree + 1;
  localparam int NW          = 5;              // holds n = d+1 and the step count
  localparam int MantW       = 32;             // normalized power mantissa
  localparam int SumW        = MantW + 1;
  localparam int ProdW       = 2 * MantW;
  localparam int DsqW        = 2 * SumW - MantW;
  localparam int NprodW      = NW + ProdW - MantW;
  localparam int QW          = SlopeW + 1;     // slope quotient plus one rounding bit
  localparam int DivW        = 56;

  localparam logic [PointW-1:0] One      = PointW'(1) << FracBits;
  localparam logic [SlopeW-1:0] SlopeMax = SlopeW'(16) << FracBits;

  typedef struct packed {
    logic              valid;
    logic [PointW-1:0] a;
    logic [PointW-1:0] b;
    logic [NW-1:0]     n;
    logic [NW-1:0]     k;
    logic [MantW-1:0]  pa;
    logic [MantW-1:0]  pb;
    logic [MantW-1:0]  pda;
    logic [MantW-1:0]  pdb;
    logic              big_shift;
  } pow_t;

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [DivW-1:0] dvs;
    logic [QW-1:0]   quo;
  } lane_t;

  typedef struct packed {
    logic  valid;
    logic  sat;
    lane_t map;
    lane_t slp;
  } div_stage_t;

  // one restoring step, divisor walks right by one bit
  function automatic lane_t div_step(lane_t l);
    lane_t r;
    r = l;
    if (l.rem >= l.dvs) begin
      r.rem = l.rem - l.dvs;
      r.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[QW-2:0], 1'b0};
    end
    r.dvs = l.dvs >> 1;
    return r;
  endfunction

endpackage

### rtl/kress_periodization_transform.sv
`timescale 1ns / 1ps
// Pipeline: 16 power cells, 3 setup stages, 22 divider cells, 1 output register.
// Throughput: one transaction per cycle; the whole pipeline advances whenever the
//   output register is empty or being taken.
// Reset: asynchronous active low; clears all valid bits and sets degree to 1.
module kress_periodization_transform import kpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,   // degree
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [16:0] point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [16:0] mapped_point, [37:17] slope
  output logic        m_axis_tuser   // [0] slope_clipped
);

  logic [DegW-1:0] degree_q;
  logic            en;

  // global stall: everything moves when the output slot frees up
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DegW'(1);
    end else if (cfg_we_i) begin
      degree_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Power chain. Cell k multiplies both running powers by a and b while k <= n,
  // renormalizing both by the same shift so their ratio survives. At k == n the
  // powers of degree d are captured along with that last shift amount.
  // ---------------------------------------------------------------------------
  pow_t              pow_chain [NumPowCells+1];
  pow_t              pow_head;
  logic [PointW-1:0] point, a_in;

  always_comb begin
    point = s_axis_tdata[PointW-1:0];
    a_in  = (point > One) ? One : point;   // points above one saturate
    pow_head           = '0;
    pow_head.valid     = s_axis_tvalid;
    pow_head.a         = a_in;
    pow_head.b         = One - a_in;
    pow_head.n         = NW'(degree_q) + NW'(1);
    pow_head.k         = NW'(1);
    pow_head.pa        = MantW'(1) << (MantW - 1);
    pow_head.pb        = MantW'(1) << (MantW - 1);
    pow_head.pda       = MantW'(1) << (MantW - 1);
    pow_head.pdb       = MantW'(1) << (MantW - 1);
    pow_head.big_shift = 1'b0;
  end

  assign pow_chain[0] = pow_head;

  for (genvar i = 0; i < NumPowCells; i++) begin : g_pow
    kpt_pow_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (en),
      .cell_i (pow_chain[i]),
      .cell_o (pow_chain[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Setup stages. A: sum of powers and x^d(1-x)^d product.
  // B: squared sum and (d+1) times the product, both kept to their top bits.
  // C: divider operands. The slope numerator carries 2^(3F+1) over the square
  // of the last normalizing shift, giving one extra quotient bit for rounding.
  // ---------------------------------------------------------------------------
  pow_t             pw;
  logic             a_valid_q, b_valid_q;
  logic [SumW-1:0]  a_sum_q, b_sum_q;
  logic [MantW-1:0] a_pa_q, b_pa_q;
  logic [ProdW-1:0] a_prod_q;
  logic [NW-1:0]    a_n_q;
  logic             a_big_q, b_big_q;
  logic [DsqW-1:0]  b_dsq_q;
  logic [NprodW-1:0] b_nprod_q;
  logic [2*SumW-1:0] sq_full;
  logic [NW+ProdW-1:0] nprod_full;

  assign pw         = pow_chain[NumPowCells];
  assign sq_full    = (2*SumW)'(a_sum_q) * (2*SumW)'(a_sum_q);
  assign nprod_full = (NW+ProdW)'(a_n_q) * (NW+ProdW)'(a_prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= pw.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sum_q   <= SumW'(pw.pa) + SumW'(pw.pb);
      a_prod_q  <= ProdW'(pw.pda) * ProdW'(pw.pdb);
      a_pa_q    <= pw.pa;
      a_n_q     <= pw.n;
      a_big_q   <= pw.big_shift;
      b_dsq_q   <= DsqW'(sq_full >> MantW);
      b_nprod_q <= NprodW'(nprod_full >> MantW);
      b_sum_q   <= a_sum_q;
      b_pa_q    <= a_pa_q;
      b_big_q   <= a_big_q;
    end
  end

  div_stage_t      div_chain [QW+1];
  div_stage_t      setup_d;
  div_stage_t      div_head_q;
  logic [DivW-1:0] slp_num;

  always_comb begin
    slp_num = b_big_q ? (DivW'(b_nprod_q) << (FracBits + 1))
                      : (DivW'(b_nprod_q) << (FracBits + 3));
    setup_d.valid   = b_valid_q;
    setup_d.map.rem = (DivW'(b_pa_q) << (FracBits + 1)) + DivW'(b_sum_q);
    setup_d.map.dvs = DivW'(b_sum_q) << QW;
    setup_d.map.quo = '0;
    setup_d.slp.rem = slp_num;
    setup_d.slp.dvs = DivW'(b_dsq_q) << (QW - 1);
    setup_d.slp.quo = '0;
    setup_d.sat     = slp_num >= (DivW'(b_dsq_q) << QW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_head_q <= '0;
    end else if (en) begin
      div_head_q <= setup_d;
    end
  end

  assign div_chain[0] = div_head_q;

  // one quotient bit per cell for both quotients
  for (genvar j = 0; j < QW; j++) begin : g_div
    kpt_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .stage_i (div_chain[j]),
      .stage_o (div_chain[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output: round the slope quotient (half up), saturate at 16.0.
  // ---------------------------------------------------------------------------
  div_stage_t        dv;
  logic [QW:0]       q_inc;
  logic [QW-1:0]     rnd;
  logic              clip;
  logic [PointW-1:0] mapped_q;
  logic [SlopeW-1:0] slope_q;
  logic              clip_q;
  logic              out_valid_q;

  always_comb begin
    dv    = div_chain[QW];
    q_inc = (QW+1)'(dv.slp.quo) + (QW+1)'(1);
    rnd   = q_inc[QW:1];
    clip  = dv.sat || (rnd > QW'(SlopeMax));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mapped_q <= dv.map.quo[PointW-1:0];
      slope_q  <= clip ? SlopeMax : rnd[SlopeW-1:0];
      clip_q   <= clip;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, slope_q, mapped_q};
  assign m_axis_tuser  = clip_q;

endmodule

### rtl/kpt_pow_cell.sv
`timescale 1ns / 1ps
module kpt_pow_cell import kpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  pow_t cell_i,
  output pow_t cell_o
);

  localparam int MulW = MantW + PointW;

  logic [MulW-1:0] prod_a, prod_b;
  logic            hi;
  pow_t            cell_d, cell_q;

  always_comb begin
    prod_a = MulW'(cell_i.pa) * MulW'(cell_i.a);
    prod_b = MulW'(cell_i.pb) * MulW'(cell_i.b);
    // larger product lies in [2^(MulW-3), 2^(MulW-1))
    hi     = prod_a[MulW-2] | prod_b[MulW-2];
    cell_d = cell_i;
    cell_d.k = cell_i.k + NW'(1);
    if (cell_i.k <= cell_i.n) begin
      cell_d.pa = hi ? MantW'(prod_a >> FracBits) : MantW'(prod_a >> (FracBits - 1));
      cell_d.pb = hi ? MantW'(prod_b >> FracBits) : MantW'(prod_b >> (FracBits - 1));
    end
    if (cell_i.k == cell_i.n) begin
      cell_d.pda       = cell_i.pa;
      cell_d.pdb       = cell_i.pb;
      cell_d.big_shift = hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/kpt_div_cell.sv
`timescale 1ns / 1ps
module kpt_div_cell import kpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  div_stage_t stage_i,
  output div_stage_t stage_o
);

  div_stage_t stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q.valid <= stage_i.valid;
      stage_q.sat   <= stage_i.sat;
      stage_q.map   <= div_step(stage_i.map);
      stage_q.slp   <= div_step(stage_i.slp);
    end
  end

  assign stage_o = stage_q;

endmodule

### tb/kress_periodization_transform_test.sv
`timescale 1ns / 1ps
module kress_periodization_transform_test;
  import kpt_pkg::*;

  // Exact arithmetic width: slope numerator peaks near 2^502.
  localparam int WideW = 640;
  typedef logic [WideW-1:0] wide_t;

  // Expected result of one point.
  typedef struct {
    logic [PointW-1:0] mapped;
    logic [SlopeW-1:0] slope;
    logic              clipped;
  } kress_result_t;

  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 60;     // covers the pipeline plus margin
  localparam int HoldStart     = 600;    // earliest receiver hold-off
  localparam int HoldLen       = 400;
  localparam int HoldMinQueued = 100;    // enough pending points to fill the pipeline
  localparam int CalmStart     = 1500;   // window with no idling on either side
  localparam int CalmLen       = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [PointW-1:0] point_queue[$];   // points waiting to be offered
  kress_result_t     kress_expected[$];
  logic [3:0]        degree_shadow = 4'd1;
  int                cycle_count = 0;
  int                errors = 0;
  logic              hold_active = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_count = 0;

  kress_periodization_transform u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // floor((2n + d) / (2d)), saturated at 2^40 - 1
  function automatic logic [63:0] round_div(wide_t n, wide_t d);
    wide_t q;
    q = ((n << 1) + d) / (d << 1);
    if (q >= (wide_t'(1) << 40)) return (64'd1 << 40) - 1;
    return q[63:0];
  endfunction

  function automatic wide_t ipow(wide_t base, int e);
    wide_t r;
    r = wide_t'(1);
    for (int i = 0; i < e; i++) r = r * base;
    return r;
  endfunction

  // Kress map and its derivative, exact ratios rounded half up.
  function automatic kress_result_t kress_predict(logic [PointW-1:0] pt, logic [3:0] deg);
    kress_result_t res;
    wide_t a, b, ea, eb, sum, num, den;
    logic [63:0] sl, mp;
    int d;
    d = (deg > MaxDegree) ? MaxDegree : int'(deg);
    a = (pt > One) ? wide_t'(One) : wide_t'(pt);   // points above one clamp to one
    b = wide_t'(One) - a;
    ea = ipow(a, d + 1);
    eb = ipow(b, d + 1);
    sum = ea + eb;
    mp = round_div(ea << FracBits, sum);
    num = ipow(a, d) * ipow(b, d) * wide_t'(d + 1);
    den = sum * sum;
    sl = round_div(num << (3 * FracBits), den);
    res.mapped  = mp[PointW-1:0];
    res.clipped = 1'b0;
    if (sl > 64'(SlopeMax)) begin
      sl = 64'(SlopeMax);
      res.clipped = 1'b1;
    end
    res.slope = sl[SlopeW-1:0];
    return res;
  endfunction

  function automatic bit near(longint x, longint y);
    return (x - y <= 1) && (y - x <= 1);
  endfunction

  function automatic bit calm_window();
    return cycle_count >= CalmStart && cycle_count < CalmStart + CalmLen;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d points pending, %0d results outstanding",
               $time, point_queue.size(), kress_expected.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver hold-off: starts once plenty of points are pending, so the
  // pipeline fills and back-pressures the input.
  always @(posedge clk_i) begin
    if (hold_active) begin
      if (hold_count == HoldLen - 1) begin
        hold_active <= 1'b0;
        hold_done   <= 1'b1;
      end
      hold_count <= hold_count + 1;
    end else if (!hold_done && cycle_count >= HoldStart &&
                 point_queue.size() > HoldMinQueued) begin
      hold_active <= 1'b1;
    end
  end

  // Driver: records each accepted transaction, then offers the next point.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        kress_expected.push_back(kress_predict(s_axis_tdata[PointW-1:0], degree_shadow));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (point_queue.size() > 0 && (calm_window() || $urandom_range(99) >= 7)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, point_queue.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: one result per transaction, one-step tolerance on both values.
  always @(posedge clk_i) begin
    kress_result_t want;
    logic [PointW-1:0] got_map;
    logic [SlopeW-1:0] got_slope;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_map   = m_axis_tdata[PointW-1:0];
        got_slope = m_axis_tdata[PointW +: SlopeW];
        if (kress_expected.size() == 0) begin
          $display("%0t: unexpected result map=%0d slope=%0d", $time, got_map, got_slope);
          errors++;
        end else begin
          want = kress_expected.pop_front();
          if (!near(longint'(want.mapped), longint'(got_map))) begin
            $display("%0t: mapped_point expected %0d actual %0d",
                     $time, want.mapped, got_map);
            errors++;
          end
          if (!near(longint'(want.slope), longint'(got_slope))) begin
            $display("%0t: slope expected %0d actual %0d", $time, want.slope, got_slope);
            errors++;
          end
          // flag may only differ where the slope sits within a step of the ceiling
          if (want.clipped !== m_axis_tuser &&
              !near(longint'(want.slope), longint'(SlopeMax))) begin
            $display("%0t: slope_clipped expected %0d actual %0d",
                     $time, want.clipped, m_axis_tuser);
            errors++;
          end
        end
      end
      m_axis_tready <= !hold_active && (calm_window() || $urandom_range(99) >= 7);
    end
  end

  // Wait for the pipeline to drain before touching the degree register.
  task automatic drain_pipeline();
    while (point_queue.size() > 0 || s_axis_tvalid || kress_expected.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_degree(logic [3:0] deg);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= deg;
    degree_shadow <= deg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random_points(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       point_queue.push_back(PointW'($urandom_range(131071)));  // includes > 1.0
        1:       point_queue.push_back(PointW'($urandom_range(64)));      // near zero
        2:       point_queue.push_back(One - PointW'($urandom_range(64))); // near one
        default: point_queue.push_back(PointW'($urandom_range(65536)));
      endcase
    end
  endtask

  logic [3:0] degree_plan[8] = '{4'd0, 4'd15, 4'd2, 4'd7, 4'd1, 4'd3, 4'd10, 4'd0};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: endpoints, midpoint, clamping above one, at reset degree and extremes.
    for (int p = 0; p < 3; p++) begin
      if (p == 1) write_degree(4'd0);
      if (p == 2) write_degree(4'd15);
      point_queue.push_back('0);
      point_queue.push_back(PointW'(1));
      point_queue.push_back(PointW'(32768));
      point_queue.push_back(PointW'(65535));
      point_queue.push_back(One);
      point_queue.push_back(One + PointW'(1));
      point_queue.push_back('1);
      point_queue.push_back(PointW'(21845));
      drain_pipeline();
    end

    foreach (degree_plan[i]) begin
      write_degree(degree_plan[i]);
      queue_random_points(235);
      drain_pipeline();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/kpt_pkg.sv
rtl/kpt_pow_cell.sv
rtl/kpt_div_cell.sv
rtl/kress_periodization_transform.sv
tb/kress_periodization_transform_test.sv
